// ===== hdl/cgig_pkg.sv =====
// cgig_pkg: shared constants, types and helper functions of the clipmap grid index generator
// used by cgig_ctrl, cgig_dp, the top level, the scoreboard and the testbench; no dependencies
`default_nettype none

package cgig_pkg;

    // grid size limits
    localparam int MAX_RES     = 64;
    localparam int SIDE_MAX    = MAX_RES + 1;
    localparam int REMAP_DEPTH = SIDE_MAX * SIDE_MAX;
    localparam int ADDR_W      = $clog2(REMAP_DEPTH);

    // field widths
    localparam int RES_W   = 7;
    localparam int COORD_W = 7;
    localparam int IDX_W   = 13;
    localparam int KIND_W  = 2;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam int IN_DATA_W  = ((2 * COORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * COORD_W + IDX_W + 7) / 8) * 8;

    // quad emission
    localparam int QUAD_LEN = 6;
    localparam int SEQ_W    = $clog2(QUAD_LEN);

    // result kinds
    localparam logic RES_VERTEX = 1'b0;
    localparam logic RES_INDEX  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_BLOCK = 2'd0,
        KIND_RING  = 2'd1,
        KIND_TRIM  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [MODE_W-1:0] {
        MODE_VERT  = 2'd0,
        MODE_CELL  = 2'd1,
        MODE_BEGIN = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND  = 2'd0,
        CFG_RES   = 2'd1,
        CFG_TRIMX = 2'd2,
        CFG_TRIMZ = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        R_NONE,
        R_VERT,
        R_BLOCK,
        R_TRIM,
        R_BEGIN
    } t_route;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_VERT,
        S_CORN,
        S_TRD,
        S_TCHK,
        S_QUAD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic             load_in;
        logic             decode;
        logic             clr_start;
        logic             clr_step;
        logic             ld_corners;
        logic             trim_hit;
        logic             trim_alloc;
        logic             emit_vert;
        logic             emit_tri;
        logic [1:0]       k;
        logic [SEQ_W-1:0] seq;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_route route;
        logic   rd_valid;
        logic   out_free;
        logic   clr_done;
    } t_status;

    // row-major index of corner k (bit 0 right, bit 1 down) of the cell at row base + x
    function automatic logic [IDX_W-1:0] corner_addr(
        input logic [IDX_W-1:0]   base,
        input logic [RES_W-1:0]   side,
        input logic [COORD_W-1:0] x,
        input logic [1:0]         k
    );
        logic [IDX_W-1:0] row_off;
        logic [IDX_W-1:0] col;
        row_off = k[1] ? IDX_W'(side) : '0;
        col     = IDX_W'(x) + IDX_W'(k[0]);
        return base + row_off + col;
    endfunction

    // corner (0 tl, 1 tr, 2 bl, 3 br) for step seq of the quad, diagonal by parity
    function automatic logic [1:0] quad_pick(input logic odd, input logic [SEQ_W-1:0] seq);
        logic [1:0] c;
        case (seq)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = odd ? 2'd2 : 2'd3;
            3'd3:    c = odd ? 2'd1 : 2'd0;
            3'd4:    c = 2'd3;
            3'd5:    c = 2'd2;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/clipmap_grid_index_generator.sv =====
// clipmap_grid_index_generator: top level, joins the controller and the datapath
// depends on cgig_pkg, cgig_ctrl and cgig_dp
//
// how to use
//   - input stream (s_axis): one request per transfer; tuser is the mode (vertex request,
//     cell request, begin mesh), tdata carries the grid column and row
//   - output stream (m_axis): vertex records and triangle corner indices; tuser tells
//     which, tlast marks the final result of a request
//   - config port: i_cfg_we / i_cfg_idx / i_cfg_data, written only while the block is idle
// timing
//   - one request at a time; a result waits in the output register while the next
//     request is taken
//   - vertex request: decode, then one result
//   - block or ring cell: six indices (decode, corner load, six emits)
//   - trim cell: each corner takes a remap memory read and a check; a new vertex record
//     goes out in the check state, then six indices
//   - requests that emit nothing return to idle from decode
//   - begin mesh: clears the remap memory one entry per cycle
// reset
//   - synchronous, active low; after reset the same clearing pass runs with
//     s_axis_tready low, config writes are taken throughout
// backpressure
//   - a stalled receiver holds the output register; the sequencer waits at its next emit
`default_nettype none

module clipmap_grid_index_generator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config write port
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_idx,
    input  wire [6:0]   i_cfg_data,
    // request stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [15:0]  s_axis_tdata,   // [6:0] grid_x, [13:7] grid_z, rest zero
    input  wire [1:0]   s_axis_tuser,   // [1:0] mode
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [6:0] vertex_col, [13:7] vertex_row, [26:14] index_value
    output logic        m_axis_tuser,   // [0] result_kind
    output logic        m_axis_tlast    // last result of the request
);
    import cgig_pkg::*;

    t_cmd    cmd;
    t_status status;

    logic [COORD_W-1:0] vertex_col;
    logic [COORD_W-1:0] vertex_row;
    logic [IDX_W-1:0]   index_value;

    // sequencer
    cgig_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // config, decode, remap memory and output register
    cgig_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (s_axis_tuser),
        .i_grid_x      (s_axis_tdata[COORD_W-1:0]),
        .i_grid_z      (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_result_kind (m_axis_tuser),
        .o_vertex_col  (vertex_col),
        .o_vertex_row  (vertex_row),
        .o_index_value (index_value),
        .o_last        (m_axis_tlast)
    );

    // pack result fields, low field first
    assign m_axis_tdata = OUT_DATA_W'({index_value, vertex_row, vertex_col});

endmodule

`default_nettype wire

// ===== hdl/cgig_ctrl.sv =====
// cgig_ctrl: sequencing state machine of the clipmap grid index generator
// depends on cgig_pkg; drives commands into cgig_dp and reads its status
`default_nettype none

module cgig_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  cgig_pkg::t_status i_status,
    output cgig_pkg::t_cmd    o_cmd
);
    import cgig_pkg::*;

    t_state           r_state, n_state;
    logic [1:0]       r_k, n_k;
    logic [SEQ_W-1:0] r_seq, n_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= '0;
            r_seq   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_seq   <= n_seq;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_seq   = r_seq;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_k   = '0;
                n_seq = '0;
                case (i_status.route)
                    R_VERT:  n_state = S_VERT;
                    R_BLOCK: n_state = S_CORN;
                    R_TRIM:  n_state = S_TRD;
                    R_BEGIN: n_state = S_CLEAR;
                    default: n_state = S_IDLE;
                endcase
            end
            S_VERT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_CORN: begin
                n_state = S_QUAD;
            end
            S_TRD: begin
                n_state = S_TCHK;
            end
            S_TCHK: begin
                if (i_status.rd_valid || i_status.out_free) begin
                    if (r_k == 2'd3) begin
                        n_state = S_QUAD;
                    end else begin
                        n_state = S_TRD;
                        n_k     = r_k + 2'd1;
                    end
                end
            end
            S_QUAD: begin
                if (i_status.out_free) begin
                    if (r_seq == SEQ_W'(QUAD_LEN - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_seq = r_seq + SEQ_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.k    = r_k;
        o_cmd.seq  = r_seq;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR:  o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.decode    = 1'b1;
                o_cmd.clr_start = (i_status.route == R_BEGIN);
            end
            S_VERT:   o_cmd.emit_vert = i_status.out_free;
            S_CORN:   o_cmd.ld_corners = 1'b1;
            S_TRD:    o_cmd.ld_corners = 1'b0;
            S_TCHK: begin
                o_cmd.trim_hit   = i_status.rd_valid;
                o_cmd.trim_alloc = !i_status.rd_valid && i_status.out_free;
            end
            S_QUAD:   o_cmd.emit_tri = i_status.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/cgig_dp.sv =====
// cgig_dp: datapath of the clipmap grid index generator: config registers, decode,
// remap memory, corner registers and output register; depends on cgig_pkg
`default_nettype none

module cgig_dp (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [cgig_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [cgig_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire [cgig_pkg::MODE_W-1:0]      i_mode,
    input  wire [cgig_pkg::COORD_W-1:0]     i_grid_x,
    input  wire [cgig_pkg::COORD_W-1:0]     i_grid_z,
    input  cgig_pkg::t_cmd                  i_cmd,
    output cgig_pkg::t_status               o_status,
    input  wire                             i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_result_kind,
    output logic [cgig_pkg::COORD_W-1:0]    o_vertex_col,
    output logic [cgig_pkg::COORD_W-1:0]    o_vertex_row,
    output logic [cgig_pkg::IDX_W-1:0]      o_index_value,
    output logic                            o_last
);
    import cgig_pkg::*;

    // configuration
    logic [KIND_W-1:0] r_kind;
    logic [RES_W-1:0]  r_res;
    logic              r_trimx;
    logic              r_trimz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_BLOCK;
            r_res   <= RES_W'(MAX_RES);
            r_trimx <= 1'b1;
            r_trimz <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KIND:  r_kind  <= i_cfg_data[KIND_W-1:0];
                CFG_RES:   r_res   <= i_cfg_data[RES_W-1:0];
                CFG_TRIMX: r_trimx <= i_cfg_data[0];
                CFG_TRIMZ: r_trimz <= i_cfg_data[0];
                default:   r_kind  <= r_kind;
            endcase
        end
    end

    // effective resolution and hole bounds
    logic [RES_W-1:0]   res;
    logic [RES_W-1:0]   side;
    logic [RES_W:0]     res3;
    logic [COORD_W-1:0] hs;
    logic [COORD_W-1:0] he;

    always_comb begin
        if (r_res == '0)                    res = RES_W'(1);
        else if (r_res > RES_W'(MAX_RES))   res = RES_W'(MAX_RES);
        else                                res = r_res;
        side = res + RES_W'(1);
        res3 = {1'b0, res} + {res, 1'b0};
        hs   = COORD_W'(res >> 2);
        he   = COORD_W'(res3 >> 2);
    end

    // input item
    logic [MODE_W-1:0]  r_mode;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_z;
    logic [IDX_W-1:0]   r_base;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= i_mode;
            r_x    <= i_grid_x;
            r_z    <= i_grid_z;
        end
        if (i_cmd.decode) begin
            r_base <= IDX_W'(r_z) * IDX_W'(side);
        end
    end

    // route decision
    t_route route;

    always_comb begin
        logic in_hole;
        logic off_gap;
        logic out_trim;
        in_hole  = (r_x >= hs) && (r_x <= he) && (r_z >= hs) && (r_z <= he);
        out_trim = (r_x < hs) || (r_x > he) || (r_z < hs) || (r_z > he);
        off_gap  = (r_x != (r_trimx ? he : hs)) && (r_z != (r_trimz ? he : hs));
        route    = R_NONE;
        case (r_mode)
            MODE_BEGIN: route = R_BEGIN;
            MODE_VERT: begin
                if (r_kind != KIND_TRIM && r_kind != KIND_NONE
                    && r_x <= res && r_z <= res) route = R_VERT;
            end
            MODE_CELL: begin
                if (r_kind == KIND_TRIM) begin
                    if (!out_trim && !off_gap) route = R_TRIM;
                end else if (r_kind != KIND_NONE && r_x < res && r_z < res) begin
                    if (!(r_kind == KIND_RING && in_hole)) route = R_BLOCK;
                end
            end
            default: route = R_NONE;
        endcase
    end

    // remap memory: valid bit on top of the assigned index
    logic [IDX_W:0]      mem [REMAP_DEPTH];
    logic [IDX_W:0]      r_rdata;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   r_clr_cnt;
    logic [IDX_W-1:0]    r_nv;
    logic [IDX_W-1:0]    cur_addr;

    assign cur_addr = corner_addr(r_base, side, r_x, i_cmd.k);
    assign rd_addr  = ADDR_W'(cur_addr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr_cnt] <= '0;
        end else if (i_cmd.trim_alloc) begin
            mem[rd_addr] <= {1'b1, r_nv};
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_nv      <= '0;
        end else begin
            if (i_cmd.clr_start) begin
                r_clr_cnt <= '0;
                r_nv      <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
            if (i_cmd.trim_alloc) r_nv <= r_nv + IDX_W'(1);
        end
    end

    // cell corners
    logic [IDX_W-1:0] r_corner [4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_corners) begin
            for (int i = 0; i < 4; i++) begin
                r_corner[i] <= corner_addr(r_base, side, r_x, 2'(i));
            end
        end else if (i_cmd.trim_hit) begin
            r_corner[i_cmd.k] <= r_rdata[IDX_W-1:0];
        end else if (i_cmd.trim_alloc) begin
            r_corner[i_cmd.k] <= r_nv;
        end
    end

    // output register
    logic out_free;
    assign out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit_vert || i_cmd.emit_tri || i_cmd.trim_alloc) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_vert) begin
            o_result_kind <= RES_VERTEX;
            o_vertex_col  <= r_x;
            o_vertex_row  <= r_z;
            o_index_value <= cur_addr;
            o_last        <= 1'b1;
        end else if (i_cmd.trim_alloc) begin
            o_result_kind <= RES_VERTEX;
            o_vertex_col  <= r_x + COORD_W'(i_cmd.k[0]);
            o_vertex_row  <= r_z + COORD_W'(i_cmd.k[1]);
            o_index_value <= r_nv;
            o_last        <= 1'b0;
        end else if (i_cmd.emit_tri) begin
            o_result_kind <= RES_INDEX;
            o_vertex_col  <= '0;
            o_vertex_row  <= '0;
            o_index_value <= r_corner[quad_pick(r_x[0] ^ r_z[0], i_cmd.seq)];
            o_last        <= (i_cmd.seq == SEQ_W'(QUAD_LEN - 1));
        end
    end

    assign o_status.route    = route;
    assign o_status.rd_valid = r_rdata[IDX_W];
    assign o_status.out_free = out_free;
    assign o_status.clr_done = (r_clr_cnt == ADDR_W'(REMAP_DEPTH - 1));

endmodule

`default_nettype wire

// ===== hdl/cgig_checker.sv =====
// cgig_checker: port-level assertions for clipmap_grid_index_generator, with its bind
// depends on the top level's port list only
`default_nettype none

module cgig_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire        m_axis_tuser,
    input wire        m_axis_tlast
);

    // the clearing pass keeps the request side closed right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request side open right after reset");

    // one request at a time: no transfer in the cycle after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while the previous one is in decode");

    // triangle indices carry no grid coordinates
    a_tri_no_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[13:0] == 14'd0)
        else $error("triangle index with nonzero coordinates");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

endmodule

bind clipmap_grid_index_generator cgig_checker u_cgig_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== tb/sv/cgig_checker.sv =====
// cgig_scoreboard: predicts the vertex records and triangle indices of the clipmap grid
// index generator from observed requests and config writes, and compares each result
// depends on cgig_pkg
`default_nettype none

module cgig_scoreboard (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [6:0]  i_cfg_data,
    input  wire        i_req_valid,
    input  wire        i_req_ready,
    input  wire [15:0] i_req_data,   // [6:0] grid_x, [13:7] grid_z
    input  wire [1:0]  i_req_mode,   // [1:0] mode
    input  wire        i_res_valid,
    input  wire        i_res_ready,
    input  wire [31:0] i_res_data,   // [6:0] vertex_col, [13:7] vertex_row, [26:14] index_value
    input  wire        i_res_kind,   // [0] result_kind
    input  wire        i_res_last,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cgig_pkg::*;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [IDX_W-1:0]   idx;
        logic               last;
    } t_mesh_out;

    // shadow copy of the config registers
    t_kind             cfg_kind   = KIND_BLOCK;
    logic [RES_W-1:0]  cfg_res    = 7'd64;
    logic              cfg_trim_x = 1'b1;
    logic              cfg_trim_z = 1'b1;

    // trim vertex numbering in order of first use
    logic [IDX_W-1:0]       vtx_id [REMAP_DEPTH];
    logic [REMAP_DEPTH-1:0] vtx_seen = '0;
    logic [IDX_W-1:0]       next_id  = '0;

    t_mesh_out mesh_out_q[$];
    t_mesh_out step_out[$];
    t_mesh_out want;
    t_mesh_out tail;
    int        fail_count    = 0;
    int        pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic add_out(input logic kind, input int col, input int row, input int idx);
        t_mesh_out r;
        r.kind = kind;
        r.col  = COORD_W'(col);
        r.row  = COORD_W'(row);
        r.idx  = IDX_W'(idx);
        r.last = 1'b0;
        step_out.push_back(r);
    endtask

    // six corners of the quad, diagonal by cell parity
    task automatic push_quad(input int tl, input int tr, input int bl, input int br,
                             input int x, input int z);
        if (((x + z) & 1) == 0) begin
            add_out(RES_INDEX, 0, 0, tl);
            add_out(RES_INDEX, 0, 0, tr);
            add_out(RES_INDEX, 0, 0, br);
            add_out(RES_INDEX, 0, 0, tl);
            add_out(RES_INDEX, 0, 0, br);
            add_out(RES_INDEX, 0, 0, bl);
        end else begin
            add_out(RES_INDEX, 0, 0, tl);
            add_out(RES_INDEX, 0, 0, tr);
            add_out(RES_INDEX, 0, 0, bl);
            add_out(RES_INDEX, 0, 0, tr);
            add_out(RES_INDEX, 0, 0, br);
            add_out(RES_INDEX, 0, 0, bl);
        end
    endtask

    // look up a trim corner, numbering and announcing it on first use
    task automatic trim_vertex(input int side, input int x, input int z, output int idx);
        int a;
        a = z * side + x;
        if (a >= REMAP_DEPTH) begin
            idx = 0;
        end else begin
            if (!vtx_seen[a]) begin
                vtx_id[a]   = next_id;
                vtx_seen[a] = 1'b1;
                next_id     = next_id + IDX_W'(1);
                add_out(RES_VERTEX, x, z, vtx_id[a]);
            end
            idx = vtx_id[a];
        end
    endtask

    task automatic predict_request(input t_mode mode, input int x, input int z);
        int r, side, hs, he, gx, gz, tl, tr, bl, br, base;
        step_out.delete();
        r    = (cfg_res < 1) ? 1 : ((cfg_res > MAX_RES) ? MAX_RES : int'(cfg_res));
        side = r + 1;
        hs   = r / 4;
        he   = (3 * r) / 4;
        if (mode == MODE_BEGIN) begin
            vtx_seen = '0;
            next_id  = '0;
        end else if (mode == MODE_VERT) begin
            if ((cfg_kind == KIND_BLOCK || cfg_kind == KIND_RING) && x <= r && z <= r)
                add_out(RES_VERTEX, x, z, z * side + x);
        end else if (mode == MODE_CELL && cfg_kind == KIND_TRIM) begin
            gx = cfg_trim_x ? he : hs;
            gz = cfg_trim_z ? he : hs;
            if (x >= hs && x <= he && z >= hs && z <= he && (x == gx || z == gz)) begin
                trim_vertex(side, x, z, tl);
                trim_vertex(side, x + 1, z, tr);
                trim_vertex(side, x, z + 1, bl);
                trim_vertex(side, x + 1, z + 1, br);
                push_quad(tl, tr, bl, br, x, z);
            end
        end else if (mode == MODE_CELL && (cfg_kind == KIND_BLOCK || cfg_kind == KIND_RING)) begin
            // ring hole spans [r/4, 3r/4] on both axes
            if (x < r && z < r &&
                !(cfg_kind == KIND_RING && x >= hs && x <= he && z >= hs && z <= he)) begin
                base = z * side + x;
                push_quad(base, base + 1, base + side, base + side + 1, x, z);
            end
        end
        if (step_out.size() != 0) begin
            tail      = step_out.pop_back();
            tail.last = 1'b1;
            step_out.push_back(tail);
            foreach (step_out[i]) mesh_out_q.push_back(step_out[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [IDX_W-1:0] exp_val,
                               input logic [IDX_W-1:0] act_val);
        if (exp_val !== act_val) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_kind   = KIND_BLOCK;
            cfg_res    = 7'd64;
            cfg_trim_x = 1'b1;
            cfg_trim_z = 1'b1;
            vtx_seen   = '0;
            next_id    = '0;
            mesh_out_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_KIND:  cfg_kind   = t_kind'(i_cfg_data[1:0]);
                    CFG_RES:   cfg_res    = i_cfg_data;
                    CFG_TRIMX: cfg_trim_x = i_cfg_data[0];
                    CFG_TRIMZ: cfg_trim_z = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                predict_request(t_mode'(i_req_mode), i_req_data[6:0], i_req_data[13:7]);
            if (i_res_valid && i_res_ready) begin
                if (mesh_out_q.size() == 0) begin
                    fail_count++;
                    $display({"%0t: result with nothing expected, actual kind %0d",
                              " col %0d row %0d index %0d last %0d"},
                             $time, i_res_kind, i_res_data[6:0], i_res_data[13:7],
                             i_res_data[26:14], i_res_last);
                end else begin
                    want = mesh_out_q.pop_front();
                    check_field("result_kind", want.kind, i_res_kind);
                    check_field("vertex_col", want.col, i_res_data[6:0]);
                    check_field("vertex_row", want.row, i_res_data[13:7]);
                    check_field("index_value", want.idx, i_res_data[26:14]);
                    check_field("last", want.last, i_res_last);
                end
            end
        end
        pending_count = mesh_out_q.size();
    end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench: drives requests and config writes into the clipmap grid index generator,
// stalls the result stream at random and reports the verdict
// depends on cgig_pkg, cgig_scoreboard and the clipmap_grid_index_generator rtl
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cgig_pkg::*;

    // time for the remap clearing pass after a begin mesh, plus margin
    localparam int DRAIN_CYCLES = 4300;
    localparam int PHASES       = 15;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = '0;
    logic [6:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [6:0] grid_x, [13:7] grid_z
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [31:0] m_axis_tdata;         // [6:0] vertex_col, [13:7] vertex_row, [26:14] index_value
    logic        m_axis_tuser;         // [0] result_kind
    logic        m_axis_tlast;

    // no idling on either side while set
    bit calm = 1'b0;
    int fail_count;
    int pending;

    clipmap_grid_index_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    cgig_scoreboard i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_mode   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_kind   (m_axis_tuser),
        .i_res_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run (the clearing passes dominate)
    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stall bursts, none while calm
    initial begin
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // one request transfer; tvalid stays high into the next request unless a gap follows
    task automatic send_req(input t_mode mode, input int x, input int z);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b00, 7'(z), 7'(x)};
        do @(posedge i_clk); while (!s_axis_tready);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // wait until every expected result has been taken, then let a clearing pass finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write all four registers on consecutive edges, write enable held high throughout
    task automatic set_mesh(input t_kind kind, input int res, input logic tx, input logic tz);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_KIND;
        i_cfg_data <= 7'(kind);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RES;
        i_cfg_data <= 7'(res);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TRIMX;
        i_cfg_data <= {6'd0, tx};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TRIMZ;
        i_cfg_data <= {6'd0, tz};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        t_kind kind;
        t_mode mode;
        int    res, eff, hs, he, gx, gz, n_items, roll, x, z;
        logic  tx, tz;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: full block at resolution 64
        send_req(MODE_VERT, 0, 0);
        send_req(MODE_VERT, 64, 64);      // far corner vertex
        send_req(MODE_VERT, 65, 3);       // column past the grid
        send_req(MODE_VERT, 0, 127);      // row past the grid
        send_req(MODE_CELL, 0, 0);        // even parity diagonal
        send_req(MODE_CELL, 1, 0);        // odd parity diagonal
        send_req(MODE_CELL, 63, 63);
        send_req(MODE_CELL, 64, 0);       // cell past the grid
        send_req(MODE_NONE, 127, 127);    // unused mode
        send_req(MODE_BEGIN, 0, 0);

        // ring at resolution 8: hole covers cells 2..6
        settle();
        set_mesh(KIND_RING, 8, 1'b1, 1'b1);
        send_req(MODE_CELL, 4, 4);        // inside the hole
        send_req(MODE_CELL, 1, 7);
        send_req(MODE_CELL, 7, 7);        // just past the hole
        send_req(MODE_VERT, 8, 8);

        // trim at resolution 8, gap row and column at the hole end (6)
        settle();
        set_mesh(KIND_TRIM, 8, 1'b1, 1'b1);
        send_req(MODE_BEGIN, 0, 0);
        send_req(MODE_CELL, 6, 2);        // four new corners
        send_req(MODE_CELL, 6, 3);        // shares its top corners
        send_req(MODE_CELL, 2, 6);
        send_req(MODE_CELL, 6, 6);        // corner of the L
        send_req(MODE_CELL, 3, 3);        // off the gap row and column
        send_req(MODE_CELL, 1, 6);        // left of the hole range
        send_req(MODE_CELL, 7, 6);        // right of the hole range
        send_req(MODE_VERT, 2, 2);        // vertex requests are dropped in trim mode

        // gap moves to the hole start without a begin: table keeps its entries
        settle();
        set_mesh(KIND_TRIM, 8, 1'b0, 1'b0);
        send_req(MODE_CELL, 2, 4);
        send_req(MODE_CELL, 5, 2);

        // unused mesh kind
        settle();
        set_mesh(KIND_NONE, 8, 1'b1, 1'b1);
        send_req(MODE_CELL, 0, 0);
        send_req(MODE_VERT, 0, 0);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0:       begin kind = KIND_TRIM;  res = 64;  tx = 1'b0; tz = 1'b0; end
                1:       begin kind = KIND_BLOCK; res = 127; tx = 1'b1; tz = 1'b1; end
                2:       begin kind = KIND_RING;  res = 0;   tx = 1'b0; tz = 1'b1; end
                3:       begin kind = KIND_TRIM;  res = 1;   tx = 1'b1; tz = 1'b0; end
                4:       begin kind = KIND_NONE;  res = 5;   tx = 1'b0; tz = 1'b1; end
                default: begin
                    roll = $urandom_range(0, 9);
                    kind = (roll < 4) ? KIND_TRIM : (roll < 6) ? KIND_BLOCK :
                           (roll < 9) ? KIND_RING : KIND_NONE;
                    // mostly small grids, some large, a few outside the legal range
                    roll = $urandom_range(0, 19);
                    if (roll < 14)
                        res = $urandom_range(1, 16);
                    else if (roll < 17)
                        res = $urandom_range(17, 64);
                    else if (roll < 18)
                        res = 0;
                    else
                        res = $urandom_range(65, 127);
                    tx = 1'($urandom_range(0, 1));
                    tz = 1'($urandom_range(0, 1));
                end
            endcase
            // the last phases and some others run with no idling at all
            calm = (p >= PHASES - 2) || ($urandom_range(0, 4) == 0);
            set_mesh(kind, res, tx, tz);

            eff = (res < 1) ? 1 : ((res > MAX_RES) ? MAX_RES : res);
            hs  = eff / 4;
            he  = (3 * eff) / 4;
            gx  = tx ? he : hs;
            gz  = tz ? he : hs;

            n_items = (kind == KIND_NONE) ? 8 : 24;
            // a trim mesh usually starts clean; sometimes it carries over the old table
            if (kind == KIND_TRIM && $urandom_range(0, 4) != 0)
                send_req(MODE_BEGIN, $urandom_range(0, 127), $urandom_range(0, 127));

            for (int i = 0; i < n_items; i++) begin
                roll = $urandom_range(0, 99);
                mode = MODE_CELL;
                x    = $urandom_range(0, eff - 1);
                z    = $urandom_range(0, eff - 1);
                if (roll >= 94) begin
                    // noise: unused mode, wild coordinates, an occasional begin
                    x = $urandom_range(0, 127);
                    z = $urandom_range(0, 127);
                    if (roll < 96)
                        mode = MODE_NONE;
                    else if (roll < 98)
                        mode = t_mode'($urandom_range(0, 1));
                    else
                        mode = MODE_BEGIN;
                end else if (roll >= 88) begin
                    // right at or just past the grid edge
                    mode = t_mode'($urandom_range(0, 1));
                    x    = eff + $urandom_range(0, 2) - 1;
                    z    = $urandom_range(0, eff + 1);
                    if ($urandom_range(0, 1) == 1) begin
                        roll = x;
                        x    = z;
                        z    = roll;
                    end
                end else if (kind == KIND_TRIM) begin
                    if (roll < 40) begin
                        x = gx;
                        z = $urandom_range(hs, he);
                    end else if (roll < 75) begin
                        z = gz;
                        x = $urandom_range(hs, he);
                    end else if (roll < 83) begin
                        mode = MODE_VERT;
                    end
                end else if (roll < 30) begin
                    mode = MODE_VERT;
                    x    = $urandom_range(0, eff);
                    z    = $urandom_range(0, eff);
                end
                send_req(mode, x, z);
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
